// ===== hdl/b64c_pkg.sv =====
// Shared types, codes and character helpers for the base64 stream codec.
// No dependencies; imported by every module of the block.
package b64c_pkg;

  localparam logic [7:0] PAD_CHAR   = 8'h3D;
  localparam logic [7:0] CHAR_UPPER = 8'h41;
  localparam logic [7:0] CHAR_LOWER = 8'h61;
  localparam logic [7:0] CHAR_DIGIT = 8'h30;
  localparam logic [7:0] CHAR_PLUS  = 8'h2B;
  localparam logic [7:0] CHAR_SLASH = 8'h2F;
  localparam logic [5:0] SEXT_LOWER = 6'd26;
  localparam logic [5:0] SEXT_DIGIT = 6'd52;
  localparam logic [5:0] SEXT_PLUS  = 6'd62;
  localparam logic [5:0] SEXT_SLASH = 6'd63;

  localparam int JOBQ_AW    = 1;
  localparam int JOBQ_DEPTH = 1 << JOBQ_AW;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_INVALID = 2'd1,
    ST_BAD_PAD = 2'd2,
    ST_TRUNC   = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    JOB_ENC,
    JOB_DEC,
    JOB_ERR
  } job_kind_e;

  // One finished group handed from the front to the back.
  // Encode: cnt = bytes present (1..3), data = bytes, missing ones zero.
  // Decode: cnt = bytes to emit (1..3), data = the four sextets packed.
  typedef struct packed {
    job_kind_e   kind;
    logic [1:0]  cnt;
    logic [23:0] data;
    status_e     status;
    logic        last;
  } job_t;

  function automatic logic [7:0] enc_char(input logic [5:0] s);
    logic [7:0] r;
    if (s < SEXT_LOWER) begin
      r = CHAR_UPPER + {2'b00, s};
    end else if (s < SEXT_DIGIT) begin
      r = CHAR_LOWER + {2'b00, s} - {2'b00, SEXT_LOWER};
    end else if (s < SEXT_PLUS) begin
      r = CHAR_DIGIT + {2'b00, s} - {2'b00, SEXT_DIGIT};
    end else if (s == SEXT_PLUS) begin
      r = CHAR_PLUS;
    end else begin
      r = CHAR_SLASH;
    end
    return r;
  endfunction

  // Returns {valid, sextet}; strict, anything outside the alphabet is invalid.
  function automatic logic [6:0] dec_sextet(input logic [7:0] c);
    logic [6:0] r;
    if (c inside {[8'h41:8'h5A]}) begin
      r = {1'b1, 6'(c - CHAR_UPPER)};
    end else if (c inside {[8'h61:8'h7A]}) begin
      r = {1'b1, 6'(c - CHAR_LOWER + {2'b00, SEXT_LOWER})};
    end else if (c inside {[8'h30:8'h39]}) begin
      r = {1'b1, 6'(c - CHAR_DIGIT + {2'b00, SEXT_DIGIT})};
    end else if (c == CHAR_PLUS) begin
      r = {1'b1, SEXT_PLUS};
    end else if (c == CHAR_SLASH) begin
      r = {1'b1, SEXT_SLASH};
    end else begin
      r = 7'd0;
    end
    return r;
  endfunction

endpackage

// ===== hdl/base64_stream_codec.sv =====
// Top level of the base64 stream codec: front end, job queue, back end.
// Depends on b64c_pkg, b64c_front, b64c_jobq, b64c_back.
//
// Base64 encoder/decoder over a byte stream, one byte per input beat with a
// last flag. mode 0 encodes three bytes into four characters ('=' pads a
// short final group), mode 1 decodes four characters into one to three
// bytes; an error gives one zero result with a status code and ends the
// message. The front end takes one input beat per cycle while the job queue
// is not full and files each finished group as a job into a two-entry queue;
// the back end walks a job out at one result beat per cycle while the
// receiver keeps popping, through a registered output. Decoding therefore
// sustains one input beat per cycle; encoding three bytes per four result
// beats, set by the single result beat the back end emits each cycle. A
// result passes the job queue, then the output register. Write mode only
// while the block is idle; a write restarts the message.
module base64_stream_codec (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic       cfg_wdata_i,
  input  logic       push,
  output logic       full,
  input  logic [7:0] in_byte_i,
  input  logic       in_last_i,
  output logic       empty,
  input  logic       pop,
  output logic [7:0] out_byte_o,
  output logic [1:0] status_o,
  output logic       out_last_o
);
  import b64c_pkg::*;

  logic q_push, q_full, q_valid, q_pop;
  job_t push_job, head_job;

  b64c_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .push        (push),
    .full        (full),
    .in_byte_i   (in_byte_i),
    .in_last_i   (in_last_i),
    .q_full_i    (q_full),
    .q_push_o    (q_push),
    .q_job_o     (push_job)
  );

  b64c_jobq u_jobq (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .job_i   (push_job),
    .full_o  (q_full),
    .valid_o (q_valid),
    .job_o   (head_job),
    .pop_i   (q_pop)
  );

  b64c_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .q_valid_i  (q_valid),
    .q_job_i    (head_job),
    .q_pop_o    (q_pop),
    .pop        (pop),
    .empty      (empty),
    .out_byte_o (out_byte_o),
    .status_o   (status_o),
    .out_last_o (out_last_o)
  );

endmodule

// ===== hdl/b64c_front.sv =====
// Front end: accepts input beats, collects groups, classifies them into jobs.
// Holds the mode register. Depends on b64c_pkg.
module b64c_front (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            cfg_we_i,
  input  logic            cfg_wdata_i,
  input  logic            push,
  output logic            full,
  input  logic [7:0]      in_byte_i,
  input  logic            in_last_i,
  input  logic            q_full_i,
  output logic            q_push_o,
  output b64c_pkg::job_t  q_job_o
);
  import b64c_pkg::*;

  logic       mode_q, mode_d;
  logic [1:0] gc_q, gc_d;
  logic       drain_q, drain_d;
  logic [7:0] buf_q [3];
  logic [7:0] buf_d [3];

  logic       acc;
  logic [1:0] gc_enc, nc;
  logic [7:0] e0, e1, e2;
  logic [6:0] d0, d1, d2, d3;
  logic       p0, p1, p2, p3;
  logic       bad_pad, bad_char;

  assign full = q_full_i;
  assign acc  = push && !q_full_i;

  // Encode view of the group with the current beat in place.
  assign gc_enc = (gc_q == 2'd3) ? 2'd0 : gc_q;
  assign nc     = gc_enc + 2'd1;
  assign e0     = (gc_enc == 2'd0) ? in_byte_i : buf_q[0];
  assign e1     = (nc < 2'd2) ? 8'd0 : ((gc_enc == 2'd1) ? in_byte_i : buf_q[1]);
  assign e2     = (nc < 2'd3) ? 8'd0 : in_byte_i;

  // Decode view of a complete group of four.
  assign p0 = (buf_q[0] == PAD_CHAR);
  assign p1 = (buf_q[1] == PAD_CHAR);
  assign p2 = (buf_q[2] == PAD_CHAR);
  assign p3 = (in_byte_i == PAD_CHAR);
  assign d0 = dec_sextet(buf_q[0]);
  assign d1 = dec_sextet(buf_q[1]);
  assign d2 = p2 ? 7'h40 : dec_sextet(buf_q[2]);
  assign d3 = p3 ? 7'h40 : dec_sextet(in_byte_i);
  assign bad_pad  = p0 || p1 || (p2 && !p3);
  assign bad_char = !(d0[6] && d1[6] && d2[6] && d3[6]);

  always_comb begin
    mode_d   = mode_q;
    gc_d     = gc_q;
    drain_d  = drain_q;
    buf_d    = buf_q;
    q_push_o = 1'b0;
    q_job_o  = '0;
    if (cfg_we_i) begin
      mode_d  = cfg_wdata_i;
      gc_d    = 2'd0;
      drain_d = 1'b0;
    end else if (acc) begin
      if (!mode_q) begin
        drain_d = 1'b0;
        if (nc == 2'd3 || in_last_i) begin
          q_push_o       = 1'b1;
          q_job_o.kind   = JOB_ENC;
          q_job_o.cnt    = nc;
          q_job_o.data   = {e0, e1, e2};
          q_job_o.status = ST_OK;
          q_job_o.last   = in_last_i;
          gc_d           = 2'd0;
        end else begin
          buf_d[gc_enc] = in_byte_i;
          gc_d          = nc;
        end
      end else if (drain_q) begin
        // drop beats up to the end of the message
        if (in_last_i) begin
          drain_d = 1'b0;
          gc_d    = 2'd0;
        end
      end else if (gc_q != 2'd3) begin
        if (in_last_i) begin
          q_push_o       = 1'b1;
          q_job_o.kind   = JOB_ERR;
          q_job_o.status = ST_TRUNC;
          q_job_o.last   = 1'b1;
          gc_d           = 2'd0;
          drain_d        = 1'b0;
        end else begin
          buf_d[gc_q] = in_byte_i;
          gc_d        = gc_q + 2'd1;
        end
      end else begin
        q_push_o = 1'b1;
        gc_d     = 2'd0;
        if (bad_pad || bad_char) begin
          q_job_o.kind   = JOB_ERR;
          q_job_o.status = bad_pad ? ST_BAD_PAD : ST_INVALID;
          q_job_o.last   = 1'b1;
          drain_d        = !in_last_i;
        end else begin
          q_job_o.kind   = JOB_DEC;
          q_job_o.cnt    = p2 ? 2'd1 : (p3 ? 2'd2 : 2'd3);
          q_job_o.data   = {d0[5:0], d1[5:0], d2[5:0], d3[5:0]};
          q_job_o.status = ST_OK;
          q_job_o.last   = in_last_i || p3;
          drain_d        = p3 && !in_last_i;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= 1'b0;
      gc_q    <= 2'd0;
      drain_q <= 1'b0;
    end else begin
      mode_q  <= mode_d;
      gc_q    <= gc_d;
      drain_q <= drain_d;
    end
  end

  always_ff @(posedge clk_i) begin
    buf_q <= buf_d;
  end

`ifndef SYNTHESIS
  a_drain_decode_only: assert property (@(posedge clk_i) disable iff (!rst_ni)
    drain_q |-> mode_q) else $error("draining set in encode mode");
  a_enc_group_short: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !mode_q |-> gc_q != 2'd3) else $error("encode group count overran");
  a_cfg_restarts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_we_i |=> gc_q == 2'd0 && !drain_q) else $error("mode write did not restart");
`endif

endmodule

// ===== hdl/b64c_jobq.sv =====
// Short job queue between front and back end.
// Depth from b64c_pkg::JOBQ_DEPTH. Depends on b64c_pkg.
module b64c_jobq (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  b64c_pkg::job_t  job_i,
  output logic            full_o,
  output logic            valid_o,
  output b64c_pkg::job_t  job_o,
  input  logic            pop_i
);
  import b64c_pkg::*;

  job_t                 mem_q [JOBQ_DEPTH];
  logic [JOBQ_AW-1:0]   wr_q, rd_q;
  logic [JOBQ_AW:0]     cnt_q;
  logic                 do_push, do_pop;

  assign full_o  = (cnt_q == (JOBQ_AW+1)'(JOBQ_DEPTH));
  assign valid_o = (cnt_q != '0);
  assign job_o   = mem_q[rd_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= job_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (do_push) wr_q <= wr_q + 1'b1;
      if (do_pop)  rd_q <= rd_q + 1'b1;
      cnt_q <= cnt_q + (JOBQ_AW+1)'(do_push) - (JOBQ_AW+1)'(do_pop);
    end
  end

`ifndef SYNTHESIS
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= (JOBQ_AW+1)'(JOBQ_DEPTH)) else $error("job queue overflow");
  a_push_gated: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(push_i && full_o)) else $error("push into full job queue");
  a_pop_gated: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> valid_o) else $error("pop from empty job queue");
`endif

endmodule

// ===== hdl/b64c_back.sv =====
// Back end: walks each job one result beat per cycle into the output register,
// while that register is empty or being popped. Depends on b64c_pkg.
module b64c_back (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            q_valid_i,
  input  b64c_pkg::job_t  q_job_i,
  output logic            q_pop_o,
  input  logic            pop,
  output logic            empty,
  output logic [7:0]      out_byte_o,
  output logic [1:0]      status_o,
  output logic            out_last_o
);
  import b64c_pkg::*;

  logic       out_v_q;
  logic [7:0] byte_q, byte_d;
  logic [1:0] status_q, status_d;
  logic       last_q, last_d;
  logic [1:0] k_q;
  logic       is_final, load, taken;
  logic [5:0] sext;
  logic [7:0] dbyte;

  assign taken = pop && out_v_q;
  assign load  = q_valid_i && (!out_v_q || taken);
  assign q_pop_o = load && is_final;

  always_comb begin
    case (k_q)
      2'd0:    sext = q_job_i.data[23:18];
      2'd1:    sext = q_job_i.data[17:12];
      2'd2:    sext = q_job_i.data[11:6];
      default: sext = q_job_i.data[5:0];
    endcase
    case (k_q)
      2'd0:    dbyte = q_job_i.data[23:16];
      2'd1:    dbyte = q_job_i.data[15:8];
      default: dbyte = q_job_i.data[7:0];
    endcase
  end

  always_comb begin
    byte_d   = 8'd0;
    status_d = ST_OK;
    last_d   = 1'b1;
    is_final = 1'b1;
    case (q_job_i.kind)
      JOB_ENC: begin
        // pad out the characters past the bytes present
        byte_d   = (k_q <= q_job_i.cnt) ? enc_char(sext) : PAD_CHAR;
        is_final = (k_q == 2'd3);
        last_d   = q_job_i.last && is_final;
      end
      JOB_DEC: begin
        byte_d   = dbyte;
        is_final = (k_q == q_job_i.cnt - 2'd1);
        last_d   = q_job_i.last && is_final;
      end
      JOB_ERR: begin
        status_d = q_job_i.status;
      end
      default: begin
        status_d = q_job_i.status;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
      k_q     <= 2'd0;
    end else begin
      if (load) begin
        out_v_q <= 1'b1;
        k_q     <= is_final ? 2'd0 : k_q + 2'd1;
      end else if (taken) begin
        out_v_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      byte_q   <= byte_d;
      status_q <= status_d;
      last_q   <= last_d;
    end
  end

  assign empty      = !out_v_q;
  assign out_byte_o = byte_q;
  assign status_o   = status_q;
  assign out_last_o = last_q;

`ifndef SYNTHESIS
  a_mid_job_head: assert property (@(posedge clk_i) disable iff (!rst_ni)
    k_q != 2'd0 |-> q_valid_i) else $error("job left the queue mid-walk");
  a_head_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (k_q != 2'd0 && !q_pop_o) |=> q_valid_i && $stable(q_job_i))
    else $error("queue head changed mid-walk");
  a_err_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (q_valid_i && q_job_i.kind == JOB_ERR) |-> k_q == 2'd0)
    else $error("error job walked past one beat");
`endif

endmodule

// ===== test/base64_stream_codec_tb.sv =====
// Self-checking testbench for base64_stream_codec: directed and random messages
// in both modes, predicted beat by beat and checked on the result side.
// Depends on b64c_pkg and the codec RTL.
`timescale 1ns / 100ps

module base64_stream_codec_tb;
  import b64c_pkg::*;

  localparam logic MODE_ENC = 1'b0;
  localparam logic MODE_DEC = 1'b1;
  localparam int CYCLE_LIMIT = 200000;
  localparam int SETTLE_CYCLES = 8;
  localparam logic [8*64-1:0] B64_ALPHA =
    "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";

  typedef struct packed {
    logic [7:0] data;
    status_e    status;
    logic       last;
  } b64_out_t;

  logic clk_i = 1'b0;
  logic rst_ni;
  logic cfg_we_i;
  logic cfg_wdata_i;
  logic push;
  logic full;
  logic [7:0] in_byte_i;
  logic in_last_i;
  logic empty;
  logic pop = 1'b0;
  logic [7:0] out_byte_o;
  logic [1:0] status_o;
  logic out_last_o;

  // predictor state
  logic cur_mode;
  logic [7:0] grp_buf[3];
  int grp_cnt;
  logic drop_rest;

  b64_out_t b64_out_q[$];
  b64_out_t want;
  int err_cnt = 0;
  int cycle_cnt = 0;
  int tx_idle_pct = 0;
  int rx_idle_pct = 0;
  int rx_hold_left = 0;

  base64_stream_codec i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i),
    .push       (push),
    .full       (full),
    .in_byte_i  (in_byte_i),
    .in_last_i  (in_last_i),
    .empty      (empty),
    .pop        (pop),
    .out_byte_o (out_byte_o),
    .status_o   (status_o),
    .out_last_o (out_last_o)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("base64_stream_codec_tb: done, errors");
      $finish;
    end
  end

  function automatic logic [7:0] alpha_char(input int idx);
    return B64_ALPHA[8*(63-idx) +: 8];
  endfunction

  function automatic void queue_result(input logic [7:0] d, input status_e st,
                                       input logic l);
    b64_out_t r;
    r.data = d;
    r.status = st;
    r.last = l;
    b64_out_q.push_back(r);
  endfunction

  // An error gives one zero beat and ends the message; drop the rest if open.
  function automatic void flag_error(input status_e st, input logic l);
    queue_result(8'h00, st, 1'b1);
    grp_cnt = 0;
    drop_rest = !l;
  endfunction

  function automatic void predict_codec_beat(input logic [7:0] b, input logic l);
    logic [23:0] word;
    logic [7:0] g[4];
    logic [5:0] v[4];
    int n;
    bit ok;
    bit found;
    if (cur_mode == MODE_ENC) begin
      if (grp_cnt > 2) grp_cnt = 0;
      drop_rest = 1'b0;
      grp_buf[grp_cnt] = b;
      grp_cnt++;
      if (grp_cnt == 3 || l) begin
        n = grp_cnt;
        word = {grp_buf[0], (n > 1) ? grp_buf[1] : 8'h00, (n > 2) ? grp_buf[2] : 8'h00};
        for (int i = 0; i < 4; i++)
          queue_result((i <= n) ? alpha_char(word[23-6*i -: 6]) : PAD_CHAR, ST_OK,
                       (i == 3) && l);
        grp_cnt = 0;
      end
    end else if (drop_rest) begin
      if (l) begin
        drop_rest = 1'b0;
        grp_cnt = 0;
      end
    end else if (grp_cnt < 3) begin
      if (l) flag_error(ST_TRUNC, l);
      else begin
        grp_buf[grp_cnt] = b;
        grp_cnt++;
      end
    end else begin
      g[0] = grp_buf[0];
      g[1] = grp_buf[1];
      g[2] = grp_buf[2];
      g[3] = b;
      if (g[0] == PAD_CHAR || g[1] == PAD_CHAR || (g[2] == PAD_CHAR && g[3] != PAD_CHAR)) begin
        flag_error(ST_BAD_PAD, l);
      end else begin
        n = 3;
        ok = 1'b1;
        for (int i = 0; i < 4; i++) begin
          v[i] = 6'd0;
          if (g[i] == PAD_CHAR) n--;
          else begin
            found = 1'b0;
            for (int k = 0; k < 64; k++)
              if (alpha_char(k) == g[i]) begin
                v[i] = 6'(k);
                found = 1'b1;
              end
            ok &= found;
          end
        end
        if (!ok) flag_error(ST_INVALID, l);
        else begin
          word = {v[0], v[1], v[2], v[3]};
          for (int i = 0; i < n; i++)
            queue_result(word[23-8*i -: 8], ST_OK,
                         (i == n - 1) && (l || g[3] == PAD_CHAR));
          grp_cnt = 0;
          drop_rest = (g[3] == PAD_CHAR) && !l;
        end
      end
    end
  endfunction

  // Offer one beat, idling at random first; push stays high afterwards.
  task automatic send_beat(input logic [7:0] b, input logic l);
    while ($urandom_range(99) < tx_idle_pct) begin
      push <= 1'b0;
      @(posedge clk_i);
    end
    push <= 1'b1;
    in_byte_i <= b;
    in_last_i <= l;
    do @(posedge clk_i); while (full);
    predict_codec_beat(b, l);
  endtask

  task automatic send_text(input string s, input logic last_at_end);
    for (int i = 0; i < s.len(); i++)
      send_beat(s[i], last_at_end && (i == s.len() - 1));
  endtask

  // Hold the input, let every expected beat arrive, then allow the pipeline to empty.
  task automatic settle_block();
    push <= 1'b0;
    while (b64_out_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic set_mode(input logic m);
    settle_block();
    cfg_wdata_i <= m;
    cfg_we_i <= 1'b1;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    cur_mode = m;
    grp_cnt = 0;
    drop_rest = 1'b0;
  endtask

  task automatic test_directed();
    // encode from the reset mode: one-byte and two-byte final groups
    send_beat(8'h00, 1'b1);
    send_beat(8'hFF, 1'b0);
    send_beat(8'h80, 1'b1);
    set_mode(MODE_DEC);
    send_text("TWFu", 1'b1);
    // pad end mid-message: drop up to the last flag
    send_text("TQ==", 1'b0);
    send_text("Z", 1'b1);
    // pad in first position, then drop
    send_text("=AAA", 1'b0);
    send_text("B", 1'b1);
    send_text("AA=A", 1'b1);
    send_beat(8'h00, 1'b0);
    send_text("AB", 1'b0);
    send_beat(8'hFF, 1'b1);
    // truncated group wins over the invalid character already held
    send_beat(8'hFF, 1'b0);
    send_text("A", 1'b1);
  endtask

  task automatic test_encode_random(input int n_items);
    int sent;
    int len;
    set_mode(MODE_ENC);
    sent = 0;
    while (sent < n_items) begin
      len = ($urandom_range(7) == 0) ? $urandom_range(10, 24) : $urandom_range(1, 7);
      for (int i = 0; i < len; i++) send_beat(8'($urandom_range(255)), i == len - 1);
      sent += len;
    end
  endtask

  task automatic test_decode_random(input int n_items);
    logic [7:0] text[$];
    int sent;
    int ngrp;
    int g;
    set_mode(MODE_DEC);
    sent = 0;
    while (sent < n_items) begin
      text.delete();
      ngrp = ($urandom_range(9) == 0) ? $urandom_range(6, 10) : $urandom_range(1, 4);
      for (int i = 0; i < 4 * ngrp; i++) text.push_back(alpha_char($urandom_range(63)));
      case ($urandom_range(2))
        1: text[$] = PAD_CHAR;
        2: begin
          text[$] = PAD_CHAR;
          text[$-1] = PAD_CHAR;
        end
        default: ;
      endcase
      // corrupt about a quarter of the messages
      if ($urandom_range(3) == 0) begin
        case ($urandom_range(3))
          0: text[$urandom_range(text.size() - 1)] = 8'($urandom_range(255));
          1: repeat ($urandom_range(1, 3)) if (text.size() > 1) void'(text.pop_back());
          2: begin
            g = $urandom_range(ngrp - 1);
            text[4*g+3] = PAD_CHAR;
            if ($urandom_range(1)) text[4*g+2] = PAD_CHAR;
          end
          default: text[$urandom_range(text.size() - 1)] = PAD_CHAR;
        endcase
      end
      foreach (text[i]) send_beat(text[i], i == text.size() - 1);
      sent += text.size();
    end
  endtask

  // Stall the receiver for a long stretch while the sender keeps pushing.
  task automatic test_backpressure();
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    set_mode(MODE_ENC);
    rx_hold_left = 400;
    for (int i = 0; i < 60; i++) send_beat(8'($urandom_range(255)), (i % 10) == 9);
    set_mode(MODE_DEC);
    rx_hold_left = 300;
    for (int i = 0; i < 40; i++) send_beat(alpha_char($urandom_range(63)), i == 39);
  endtask

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (pop && !empty) begin
        if (b64_out_q.size() == 0) begin
          $display("%0t: result beat with none expected: byte %02h status %0d last %0b",
                   $time, out_byte_o, status_o, out_last_o);
          err_cnt++;
        end else begin
          want = b64_out_q.pop_front();
          if (out_byte_o !== want.data) begin
            $display("%0t: out_byte expected %02h actual %02h", $time, want.data, out_byte_o);
            err_cnt++;
          end
          if (status_o !== want.status) begin
            $display("%0t: status expected %0d actual %0d", $time, want.status, status_o);
            err_cnt++;
          end
          if (out_last_o !== want.last) begin
            $display("%0t: out_last expected %0b actual %0b", $time, want.last, out_last_o);
            err_cnt++;
          end
        end
      end
      if (rx_hold_left > 0) begin
        rx_hold_left--;
        pop <= 1'b0;
      end else begin
        pop <= ($urandom_range(99) >= rx_idle_pct);
      end
    end
  end

  initial begin
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_wdata_i = MODE_ENC;
    push = 1'b0;
    in_byte_i = 8'h00;
    in_last_i = 1'b0;
    cur_mode = MODE_ENC;
    grp_buf = '{default: 8'h00};
    grp_cnt = 0;
    drop_rest = 1'b0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    tx_idle_pct = 21;
    rx_idle_pct = 65;
    test_encode_random(50);
    test_decode_random(50);
    tx_idle_pct = 65;
    rx_idle_pct = 21;
    test_encode_random(50);
    test_decode_random(50);
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    test_encode_random(50);
    test_decode_random(50);
    test_backpressure();
    settle_block();
    if (err_cnt == 0) $display("base64_stream_codec_tb: done, clean");
    else $display("base64_stream_codec_tb: done, errors");
    $finish;
  end

endmodule
